// ----- design/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, codes and calendar helpers for the calendar clock step block.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned YearW = 14;
  localparam logic [YearW-1:0] YEAR_TOP = 14'd16383;

  typedef enum logic [1:0] {
    KIND_UP   = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_LOAD = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    UNIT_SEC   = 3'd0,
    UNIT_MIN   = 3'd1,
    UNIT_HOUR  = 3'd2,
    UNIT_DAY   = 3'd3,
    UNIT_MONTH = 3'd4,
    UNIT_YEAR  = 3'd5
  } unit_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_UNDER    = 2'd2,
    ST_OVER     = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [YearW-1:0] year;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } stamp_t;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    is_leap = (y[1:0] == 2'd0);
  endfunction

  function automatic logic short_month(input logic [3:0] m);
    short_month = (m == 4'd4) || (m == 4'd6) || (m == 4'd9) || (m == 4'd11);
  endfunction

  // days in month, February as a common year; codes 0 and 13..15 give 0
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    month_len = len;
  endfunction

endpackage

// ----- design/ccs_load_chk.sv -----
// ----------------------------------------------------------------------------
// ccs_load_chk
// Range check of a date and time offered for loading.
// ----------------------------------------------------------------------------
module ccs_load_chk import ccs_pkg::*; (
  input  stamp_t ld_i,
  output logic   ok_o
);

  logic [4:0] lim;

  always_comb begin
    lim = month_len(ld_i.month);
    if (ld_i.month == 4'd2 && is_leap(ld_i.year)) begin
      lim = 5'd29;
    end
    // year field cannot exceed YEAR_TOP at this width
    ok_o = (ld_i.hour <= 5'd23) && (ld_i.minute <= 6'd59) && (ld_i.second <= 6'd59) &&
           (ld_i.month >= 4'd1) && (ld_i.month <= 4'd12) && (ld_i.day >= 5'd1) &&
           (ld_i.year <= YEAR_TOP) && (ld_i.day <= lim);
  end

endmodule

// ----- design/ccs_step.sv -----
// ----------------------------------------------------------------------------
// ccs_step
// Next date and time for one command: step up with carry, step down with
// borrow, or checked load.
// ----------------------------------------------------------------------------
module ccs_step import ccs_pkg::*; (
  input  stamp_t      cur_i,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  unit_i,
  input  stamp_t      ld_i,
  output stamp_t      nxt_o,
  output status_e     status_o
);

  logic    ld_ok;
  stamp_t  up_t, dn_t;
  status_e up_st, dn_st;

  // up chain
  logic ug_sec, ug_min, ug_hr, ug_day, ug_mon, ug_yr, day_end;
  // down chain
  logic dg_sec, dg_min, dg_hr, dg_day, dg_mon, mon_borrow, yr_dec;
  logic [4:0] prev_len;

  ccs_load_chk u_load_chk (
    .ld_i (ld_i),
    .ok_o (ld_ok)
  );

  always_comb begin
    ug_sec = (unit_i == UNIT_SEC);
    ug_min = (unit_i == UNIT_MIN)  || (ug_sec && cur_i.second >= 6'd59);
    ug_hr  = (unit_i == UNIT_HOUR) || (ug_min && cur_i.minute >= 6'd59);
    ug_day = (unit_i == UNIT_DAY)  || (ug_hr && cur_i.hour >= 5'd23);
    day_end = (cur_i.day == 5'd28 && cur_i.month == 4'd2 && !is_leap(cur_i.year)) ||
              (cur_i.day == 5'd29 && cur_i.month == 4'd2) ||
              (cur_i.day == 5'd30 && short_month(cur_i.month)) ||
              (cur_i.day >= 5'd31);
    ug_mon = (unit_i == UNIT_MONTH) || (ug_day && day_end);
    ug_yr  = (unit_i == UNIT_YEAR)  || (ug_mon && cur_i.month >= 4'd12);

    up_t = cur_i;
    if (ug_sec) begin
      up_t.second = (cur_i.second >= 6'd59) ? 6'd0 : cur_i.second + 6'd1;
    end
    if (ug_min) begin
      up_t.minute = (cur_i.minute >= 6'd59) ? 6'd0 : cur_i.minute + 6'd1;
    end
    if (ug_hr) begin
      up_t.hour = (cur_i.hour >= 5'd23) ? 5'd0 : cur_i.hour + 5'd1;
    end
    if (ug_day) begin
      up_t.day = day_end ? 5'd1 : cur_i.day + 5'd1;
    end
    if (ug_mon) begin
      up_t.month = (cur_i.month >= 4'd12) ? 4'd1 : cur_i.month + 4'd1;
    end
    if (ug_yr) begin
      up_t.year = cur_i.year + 14'd1;
    end
    up_st = (ug_yr && cur_i.year >= YEAR_TOP) ? ST_OVER : ST_OK;
  end

  always_comb begin
    dg_sec = (unit_i == UNIT_SEC);
    dg_min = (unit_i == UNIT_MIN)  || (dg_sec && cur_i.second == 6'd0);
    dg_hr  = (unit_i == UNIT_HOUR) || (dg_min && cur_i.minute == 6'd0);
    dg_day = (unit_i == UNIT_DAY)  || (dg_hr && cur_i.hour == 5'd0);
    dg_mon = (unit_i == UNIT_MONTH) || (dg_day && cur_i.day <= 5'd1);
    mon_borrow = dg_mon && (cur_i.month <= 4'd1);
    // a year step alone saturates at zero
    yr_dec = ((unit_i == UNIT_YEAR) || mon_borrow) && (cur_i.year != '0);

    // length of the month before the current one
    if (cur_i.month <= 4'd1) begin
      prev_len = 5'd31;
    end else if (cur_i.month == 4'd3) begin
      prev_len = is_leap(cur_i.year) ? 5'd29 : 5'd28;
    end else if (cur_i.month == 4'd5 || cur_i.month == 4'd7 ||
                 cur_i.month == 4'd10 || cur_i.month == 4'd12) begin
      prev_len = 5'd30;
    end else begin
      prev_len = 5'd31;
    end

    dn_t = cur_i;
    if (dg_sec) begin
      dn_t.second = (cur_i.second == 6'd0) ? 6'd59 : cur_i.second - 6'd1;
    end
    if (dg_min) begin
      dn_t.minute = (cur_i.minute == 6'd0) ? 6'd59 : cur_i.minute - 6'd1;
    end
    if (dg_hr) begin
      dn_t.hour = (cur_i.hour == 5'd0) ? 5'd23 : cur_i.hour - 5'd1;
    end
    if (dg_day) begin
      dn_t.day = (cur_i.day > 5'd1) ? cur_i.day - 5'd1 : prev_len;
    end
    if (dg_mon) begin
      dn_t.month = mon_borrow ? 4'd12 : cur_i.month - 4'd1;
    end
    if (yr_dec) begin
      dn_t.year = cur_i.year - 14'd1;
    end
    dn_st = (mon_borrow && cur_i.year == '0) ? ST_UNDER : ST_OK;
  end

  always_comb begin
    case (kind_i)
      KIND_UP: begin
        status_o = up_st;
        nxt_o    = (up_st == ST_OK) ? up_t : cur_i;
      end
      KIND_DOWN: begin
        status_o = dn_st;
        nxt_o    = (dn_st == ST_OK) ? dn_t : cur_i;
      end
      KIND_LOAD: begin
        status_o = ld_ok ? ST_OK : ST_BAD_LOAD;
        nxt_o    = ld_ok ? ld_i : cur_i;
      end
      default: begin
        status_o = ST_OK;
        nxt_o    = cur_i;
      end
    endcase
  end

endmodule

// ----- design/calendar_clock_step.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_step
// Date and time keeper: one step-up, step-down or load command per word.
// ----------------------------------------------------------------------------
// Path: a word is taken into the input register, passes the step logic and is
// captured in the result register, which drives result valid.
// Throughput: one word per cycle unless the output stalls; the held date and
// time updates as each word enters the result register, so words chain directly.
// Reset: date and time return to 1/1/2007 00:00:00, both stages empty.
module calendar_clock_step import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  unit_i,
  input  logic [4:0]  load_day_i,
  input  logic [3:0]  load_month_i,
  input  logic [13:0] load_year_i,
  input  logic [4:0]  load_hour_i,
  input  logic [5:0]  load_minute_i,
  input  logic [5:0]  load_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  cur_day_o,
  output logic [3:0]  cur_month_o,
  output logic [13:0] cur_year_o,
  output logic [4:0]  cur_hour_o,
  output logic [5:0]  cur_minute_o,
  output logic [5:0]  cur_second_o,
  output logic [1:0]  status_o
);

  localparam stamp_t RESET_STAMP = '{day: 5'd1, month: 4'd1, year: 14'd2007,
                                     hour: 5'd0, minute: 6'd0, second: 6'd0};

  logic       s1_vld_q;
  logic [1:0] s1_kind_q;
  logic [2:0] s1_unit_q;
  stamp_t     s1_ld_q;

  logic       out_vld_q;
  stamp_t     out_q;
  status_e    out_st_q;

  stamp_t     state_q, state_d;
  status_e    step_st;

  logic advance, s1_move, in_take;

  assign advance    = !out_vld_q || !out_stall_i;
  assign s1_move    = s1_vld_q && advance;
  assign in_stall_o = s1_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  ccs_step u_step (
    .cur_i    (state_q),
    .kind_i   (s1_kind_q),
    .unit_i   (s1_unit_q),
    .ld_i     (s1_ld_q),
    .nxt_o    (state_d),
    .status_o (step_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= RESET_STAMP;
    end else begin
      if (in_take) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= s1_vld_q;
      end
      if (s1_move) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q       <= kind_i;
      s1_unit_q       <= unit_i;
      s1_ld_q.day     <= load_day_i;
      s1_ld_q.month   <= load_month_i;
      s1_ld_q.year    <= load_year_i;
      s1_ld_q.hour    <= load_hour_i;
      s1_ld_q.minute  <= load_minute_i;
      s1_ld_q.second  <= load_second_i;
    end
    if (s1_move) begin
      out_q    <= state_d;
      out_st_q <= step_st;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cur_day_o    = out_q.day;
  assign cur_month_o  = out_q.month;
  assign cur_year_o   = out_q.year;
  assign cur_hour_o   = out_q.hour;
  assign cur_minute_o = out_q.minute;
  assign cur_second_o = out_q.second;
  assign status_o     = out_st_q;

endmodule
